>>> hw/rtl/fdf_pkg.sv
// Shared types and constants for the flooded-discovery duplicate filter.
// No dependencies; imported by fdf_cell and flood_duplicate_filter.

package fdf_pkg;

    // Fixed field widths of the stream payload.
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 32;
    localparam int IN_SEQ_W = 16;
    localparam int CNT_W    = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Command codes carried in tuser.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_AGE   = 1'b1;

    // Register selection by paddr[3].
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_STALE   = 1'b1;

    localparam logic [TIME_W-1:0] STALE_RESET = 32'd10000;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic             active;
        logic             hit;
        logic             is_new;
        logic             free_found;
        logic [CNT_W-1:0] count;
    } tok_t;

    // Query broadcast to every cell while a transaction is being processed.
    typedef struct packed {
        logic              cmd;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] ts;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] stale;
        logic              start;
        logic              commit;
    } qry_t;

endpackage

>>> hw/rtl/fdf_cell.sv
// One table entry of the duplicate filter, with its slice of the token chain.
// Depends on fdf_pkg for the token and query types.

module fdf_cell #(
    parameter int SEQ_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fdf_pkg::qry_t      qry,
    input  logic [SEQ_W-1:0]   qry_seq,
    input  fdf_pkg::tok_t      tok_in,
    output fdf_pkg::tok_t      tok_out
);
    import fdf_pkg::*;

    logic              valid_reg, valid_next;
    logic              claim_reg, claim_next;
    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    tok_t              tok_reg, tok_next;

    logic              hit_here;
    logic              newer;
    logic [TIME_W-1:0] age;
    logic              stale;

    // Compare the passing query with this entry and update the token.
    always_comb
    begin
        hit_here = valid_reg && (mac_reg == qry.mac);
        newer    = (qry.ts > time_reg) || ((qry.ts == time_reg) && (qry_seq > seq_reg));
        age      = qry.now - time_reg;
        stale    = valid_reg && (qry.now > time_reg) && (age > qry.stale);

        tok_next   = tok_in;
        valid_next = valid_reg;
        mac_next   = mac_reg;
        time_next  = time_reg;
        seq_next   = seq_reg;
        claim_next = qry.start ? 1'b0 : claim_reg;

        if (tok_in.active)
        begin
            if (qry.cmd == CMD_CHECK)
            begin
                if (hit_here && !tok_in.hit)
                begin
                    tok_next.hit = 1'b1;
                    if (newer)
                    begin
                        tok_next.is_new = 1'b1;
                        time_next       = qry.ts;
                        seq_next        = qry_seq;
                    end
                end
                else if (!valid_reg && !tok_in.free_found)
                begin
                    // The lowest free entry reserves itself for a later insert.
                    tok_next.free_found = 1'b1;
                    claim_next          = 1'b1;
                end
            end
            else if (stale)
            begin
                valid_next = 1'b0;
                if (tok_in.count != CNT_MAX)
                begin
                    tok_next.count = tok_in.count + 1'b1;
                end
            end
        end

        // Insert an unknown MAC into the reserved entry.
        if (qry.commit && claim_reg)
        begin
            valid_next = 1'b1;
            mac_next   = qry.mac;
            time_next  = qry.ts;
            seq_next   = qry_seq;
        end
    end

    // Control state of the entry and the token stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry payload; only read while the entry is valid.
    always_ff @(posedge clk)
    begin
        mac_reg  <= mac_next;
        time_reg <= time_next;
        seq_reg  <= seq_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/flood_duplicate_filter.sv
// Top level of the flooded-discovery duplicate filter: APB registers,
// transaction control and the row of fdf_cell entries. Depends on fdf_pkg.
//
//  Channel   Role          Transaction carries
//  s_*       stream in     tuser: cmd; tdata: src_mac, pkt_timestamp, pkt_seq, now_time
//  m_*       stream out    tdata: is_new, table_full, removed_count
//  APB       registers     own_mac at 0x0, stale_interval at 0x8
//
// After acceptance, the token walks the row of cells one entry per cycle;
// a check of the switch's own MAC skips the row.
// Reset clears all entries at once through their valid bits; no sweep.
// A stalled result is held in the output register; the next transaction is
// accepted only once the previous result has moved into that register.

module flood_duplicate_filter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SEQ_BITS      = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // src_mac[47:0], pkt_timestamp[79:48],
                                   // pkt_seq[95:80], now_time[127:96]
    input  logic         s_tuser,  // cmd[0]
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata   // is_new[0], table_full[1],
                                   // removed_count[8:2], zero[15:9]
);
    import fdf_pkg::*;

    localparam int SEQ_W = (SEQ_BITS < IN_SEQ_W) ? SEQ_BITS : IN_SEQ_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [MAC_W-1:0]  own_mac_reg;
    logic [TIME_W-1:0] stale_reg;
    logic              cmd_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TIME_W-1:0] ts_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              start_reg, start_next;
    logic              commit_reg, commit_next;
    logic [8:0]        res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [8:0]        m_data_reg, m_data_next;

    logic              in_fire;
    logic              cfg_wr;
    qry_t              qry;
    tok_t              tok [TABLE_ENTRIES+1];
    tok_t              tail;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            stale_reg   <= STALE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_OWN_MAC)
            begin
                own_mac_reg <= pwdata[MAC_W-1:0];
            end
            else
            begin
                stale_reg <= pwdata[TIME_W-1:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_STALE) ? {32'd0, stale_reg} : {16'd0, own_mac_reg};

    // Latch the query of an accepted transaction.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= s_tuser;
            mac_reg <= s_tdata[47:0];
            ts_reg  <= s_tdata[79:48];
            seq_reg <= s_tdata[80 +: SEQ_W];
            now_reg <= s_tdata[127:96];
        end
    end

    // Query broadcast to every cell.
    always_comb
    begin
        qry.cmd    = cmd_reg;
        qry.mac    = mac_reg;
        qry.ts     = ts_reg;
        qry.now    = now_reg;
        qry.stale  = stale_reg;
        qry.start  = start_reg;
        qry.commit = commit_reg;
    end

    // Token head: a fresh token enters the first cell when a scan starts.
    assign tok[0] = {start_reg, 1'b0, 1'b0, 1'b0, {CNT_W{1'b0}}};

    // Row of table entries.
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        fdf_cell #(
            .SEQ_W (SEQ_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .qry     (qry),
            .qry_seq (seq_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail = tok[TABLE_ENTRIES];

    // Transaction control and result formation.
    always_comb
    begin
        state_next    = state_reg;
        start_next    = 1'b0;
        commit_next   = 1'b0;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((s_tuser == CMD_CHECK) && (s_tdata[47:0] == own_mac_reg))
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tail.active)
                begin
                    if (cmd_reg == CMD_AGE)
                    begin
                        res_next = {tail.count, 1'b0, 1'b0};
                    end
                    else if (tail.hit)
                    begin
                        res_next = {{CNT_W{1'b0}}, 1'b0, tail.is_new};
                    end
                    else if (tail.free_found)
                    begin
                        res_next    = {{CNT_W{1'b0}}, 1'b0, 1'b1};
                        commit_next = 1'b1;
                    end
                    else
                    begin
                        res_next = {{CNT_W{1'b0}}, 1'b1, 1'b1};
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_data_next   = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            commit_reg   <= 1'b0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            commit_reg   <= commit_next;
            res_reg      <= res_next;
            m_tvalid_reg <= m_tvalid_next;
            m_data_reg   <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

`ifndef SYNTHESIS
    // The token only leaves the row while a scan is in progress.
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == ST_SCAN))
        else $error("token left the row outside a scan");

    // An insert is committed only right after a scan ends.
    a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        commit_reg |-> (state_reg == ST_OUT) && $past(state_reg == ST_SCAN))
        else $error("insert committed outside the result cycle");

    // A packet can be found newer only at a matching entry.
    a_new_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.active && !tail.hit) |-> !tail.is_new)
        else $error("token marked new without a hit");

    // A scan starts in the cycle after acceptance.
    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == ST_SCAN) && $past(in_fire))
        else $error("scan started without an accepted transaction");
`endif

endmodule
